// ----- src/wsp_pkg.sv -----
// Shared types and constants for the worklist shortest-path block.
`default_nettype none
package wsp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 8192;
  localparam int WEIGHT_BITS  = 16;

  localparam int VTX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int EDGE_AW = 13;
  localparam int IDX_W   = 14;
  localparam int DIST_W  = 24;
  localparam int EDGE_DW = 2 * VTX_W + WEIGHT_BITS;

  localparam logic [DIST_W-1:0] UNREACHED = 24'd9999999;
  localparam logic [CNT_W-1:0]  VTX_MAX   = CNT_W'(MAX_VERTICES);
  localparam logic [IDX_W-1:0]  EDGE_MAX  = IDX_W'(MAX_EDGES);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEL_QUERY = 2'd0,
    SEL_FROM  = 2'd1,
    SEL_TO    = 2'd2
  } dist_sel_t;

  typedef struct packed {
    logic      capture;
    logic      idx_clr;
    logic      idx_inc;
    logic      edge_wr_match;
    logic      edge_wr_new;
    logic      set_ovf;
    logic      clr_edges;
    logic      init_wr;
    logic      start_wr;
    logic      lat_dfrom;
    logic      relax;
    logic      chg_clr;
    logic      res_run;
    logic      res_query;
    dist_sel_t dist_sel;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  start_oor;
    logic  query_oor;
    logic  idx_at_fill;
    logic  fill_full;
    logic  edge_match;
    logic  edge_oor;
    logic  changed;
    logic  init_last;
  } stat_t;

endpackage
`default_nettype wire

// ----- src/worklist_shortest_path.sv -----
// Top level of the worklist shortest-path block.
//
// Usage:
// - Command channel: a transaction is taken at a clock edge with start high
//   and busy low. mode selects load edge, run, read distance or clear edges.
// - Loads search the edge table for the same (from, to) pair, then replace
//   the weight or append. A full table drops the edge and sets a sticky
//   overflow flag that only a clear or a reset removes.
// - A run writes every in-use distance to 9999999, sets the start vertex to
//   0, then sweeps the edge table relaxing edges until a pass makes no
//   improvement. Only edges with both endpoints in range are relaxed; the
//   number of sweeps depends on the graph (at most one more than the longest
//   shortest-path hop count).
// - Results appear on distance, reached and status for one cycle with done
//   high; the receiver must take them then, it cannot stall the block.
// - Config: vertex_count written via cfg_valid/cfg_ready while idle.
// - Synchronous reset: empty table, flag clear, vertex_count 1024. Distance
//   memory holds garbage until the first run.
`default_nettype none
module worklist_shortest_path import wsp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic [1:0]             mode,
  input  wire logic [VTX_W-1:0]       edge_from,
  input  wire logic [VTX_W-1:0]       edge_to,
  input  wire logic [WEIGHT_BITS-1:0] edge_weight,
  input  wire logic [VTX_W-1:0]       start_vertex,
  input  wire logic [VTX_W-1:0]       query_vertex,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data,
  output      logic                   done,
  output      logic [DIST_W-1:0]      distance,
  output      logic                   reached,
  output      logic [1:0]             status
);

  cmd_t  cmd;
  stat_t stat;

  wsp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  wsp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .edge_from    (edge_from),
    .edge_to      (edge_to),
    .edge_weight  (edge_weight),
    .start_vertex (start_vertex),
    .query_vertex (query_vertex),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .distance     (distance),
    .reached      (reached),
    .status       (status)
  );

endmodule
`default_nettype wire

// ----- src/wsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/wsp_ctrl.sv -----
// Sequencer for edge loads, relaxation passes and distance reads.
`default_nettype none
module wsp_ctrl import wsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output      logic  busy,
  input  wire stat_t stat,
  output      cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DISPATCH = 11'b00000000010,
    S_L_RD     = 11'b00000000100,
    S_L_CMP    = 11'b00000001000,
    S_INIT     = 11'b00000010000,
    S_START_W  = 11'b00000100000,
    S_P_RD     = 11'b00001000000,
    S_P_EDGE   = 11'b00010000000,
    S_P_FROM   = 11'b00100000000,
    S_P_TO     = 11'b01000000000,
    S_Q_WAIT   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.dist_sel = SEL_QUERY;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          MODE_CLEAR: begin
            cmd.clr_edges = 1'b1;
            state_next    = S_IDLE;
          end
          MODE_LOAD: state_next = S_L_CMP;
          MODE_RUN: begin
            if (stat.start_oor) begin
              cmd.res_run = 1'b1;
              state_next  = S_IDLE;
            end else begin
              state_next = S_INIT;
            end
          end
          MODE_READ: begin
            if (stat.query_oor) begin
              cmd.res_query = 1'b1;
              state_next    = S_IDLE;
            end else begin
              cmd.dist_sel = SEL_QUERY;
              state_next   = S_Q_WAIT;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_L_RD: state_next = S_L_CMP;
      S_L_CMP: begin
        if (stat.idx_at_fill) begin
          if (stat.fill_full) begin
            cmd.set_ovf = 1'b1;
          end else begin
            cmd.edge_wr_new = 1'b1;
          end
          state_next = S_IDLE;
        end else if (stat.edge_match) begin
          cmd.edge_wr_match = 1'b1;
          state_next        = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_L_RD;
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_START_W;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_START_W: begin
        cmd.start_wr = 1'b1;
        cmd.chg_clr  = 1'b1;
        state_next   = S_P_RD;
      end
      S_P_RD: state_next = S_P_EDGE;
      S_P_EDGE: begin
        if (stat.idx_at_fill) begin
          if (stat.changed) begin
            cmd.idx_clr = 1'b1;
            cmd.chg_clr = 1'b1;
            state_next  = S_P_RD;
          end else begin
            cmd.res_run = 1'b1;
            state_next  = S_IDLE;
          end
        end else if (stat.edge_oor) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_P_RD;
        end else begin
          cmd.dist_sel = SEL_FROM;
          state_next   = S_P_FROM;
        end
      end
      S_P_FROM: begin
        cmd.lat_dfrom = 1'b1;
        cmd.dist_sel  = SEL_TO;
        state_next    = S_P_TO;
      end
      S_P_TO: begin
        cmd.relax   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_P_RD;
      end
      S_Q_WAIT: begin
        cmd.res_query = 1'b1;
        state_next    = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/wsp_dpath.sv -----
// Edge table, distance memory, counters and result registers.
`default_nettype none
module wsp_dpath import wsp_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output      stat_t                  stat,
  input  wire logic [1:0]             mode,
  input  wire logic [VTX_W-1:0]       edge_from,
  input  wire logic [VTX_W-1:0]       edge_to,
  input  wire logic [WEIGHT_BITS-1:0] edge_weight,
  input  wire logic [VTX_W-1:0]       start_vertex,
  input  wire logic [VTX_W-1:0]       query_vertex,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data,
  output      logic                   done,
  output      logic [DIST_W-1:0]      distance,
  output      logic                   reached,
  output      logic [1:0]             status
);

  logic [CNT_W-1:0]       vertex_count;
  logic [IDX_W-1:0]       fill;
  logic                   ovf;
  logic                   changed;
  logic [IDX_W-1:0]       idx;
  mode_t                  mode_r;
  logic [VTX_W-1:0]       efrom_r, eto_r, start_r, query_r;
  logic [WEIGHT_BITS-1:0] ew_r;
  logic [DIST_W-1:0]      dfrom;

  logic [CNT_W-1:0]   n_use;
  logic [EDGE_DW-1:0] edge_rdata, edge_wdata;
  logic [EDGE_AW-1:0] edge_waddr;
  logic               edge_we;
  logic [VTX_W-1:0]   rd_from, rd_to;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [DIST_W-1:0]  dist_rdata, dist_wdata;
  logic [VTX_W-1:0]   dist_raddr, dist_waddr;
  logic               dist_we;
  logic [DIST_W:0]    cand;
  logic               better;
  logic [CNT_W-1:0]   idx_p1;

  assign cfg_ready = 1'b1;
  assign n_use = (vertex_count > VTX_MAX) ? VTX_MAX : vertex_count;

  assign rd_from = edge_rdata[EDGE_DW-1 -: VTX_W];
  assign rd_to   = edge_rdata[WEIGHT_BITS +: VTX_W];
  assign rd_w    = edge_rdata[WEIGHT_BITS-1:0];

  assign cand   = {1'b0, dfrom} + (DIST_W+1)'(rd_w);
  assign better = cand < {1'b0, dist_rdata};
  assign idx_p1 = idx[CNT_W-1:0] + CNT_W'(1);

  always_comb begin
    stat.mode        = mode_r;
    stat.start_oor   = {1'b0, start_r} >= n_use;
    stat.query_oor   = {1'b0, query_r} >= n_use;
    stat.idx_at_fill = (idx == fill);
    stat.fill_full   = (fill == EDGE_MAX);
    stat.edge_match  = (rd_from == efrom_r) && (rd_to == eto_r);
    stat.edge_oor    = ({1'b0, rd_from} >= n_use) || ({1'b0, rd_to} >= n_use);
    stat.changed     = changed;
    stat.init_last   = (idx_p1 == n_use);
  end

  // edge table: {from, to, weight}
  assign edge_we    = cmd.edge_wr_match | cmd.edge_wr_new;
  assign edge_waddr = cmd.edge_wr_new ? fill[EDGE_AW-1:0] : idx[EDGE_AW-1:0];
  assign edge_wdata = {efrom_r, eto_r, ew_r};

  wsp_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (idx[EDGE_AW-1:0]),
    .rdata (edge_rdata)
  );

  always_comb begin
    case (cmd.dist_sel)
      SEL_FROM: dist_raddr = rd_from;
      SEL_TO:   dist_raddr = rd_to;
      default:  dist_raddr = query_r;
    endcase
  end

  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = idx[VTX_W-1:0];
    dist_wdata = UNREACHED;
    if (cmd.init_wr) begin
      dist_we = 1'b1;
    end else if (cmd.start_wr) begin
      dist_we    = 1'b1;
      dist_waddr = start_r;
      dist_wdata = '0;
    end else if (cmd.relax && better) begin
      dist_we    = 1'b1;
      dist_waddr = rd_to;
      dist_wdata = cand[DIST_W-1:0];
    end
  end

  wsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  // latched item fields and relax operand
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= mode_t'(mode);
      efrom_r <= edge_from;
      eto_r   <= edge_to;
      ew_r    <= edge_weight;
      start_r <= start_vertex;
      query_r <= query_vertex;
    end
    if (cmd.lat_dfrom) begin
      dfrom <= dist_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VTX_MAX;
      fill         <= '0;
      ovf          <= 1'b0;
      changed      <= 1'b0;
      idx          <= '0;
      done         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      if (cmd.clr_edges) begin
        fill <= '0;
        ovf  <= 1'b0;
      end else begin
        if (cmd.edge_wr_new) begin
          fill <= fill + IDX_W'(1);
        end
        if (cmd.set_ovf) begin
          ovf <= 1'b1;
        end
      end
      if (cmd.chg_clr) begin
        changed <= 1'b0;
      end else if (cmd.relax && better) begin
        changed <= 1'b1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      done <= cmd.res_run | cmd.res_query;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_run) begin
      distance <= '0;
      reached  <= 1'b0;
      if (stat.start_oor) begin
        status <= ST_RANGE;
      end else if (ovf) begin
        status <= ST_OVF;
      end else begin
        status <= ST_OK;
      end
    end else if (cmd.res_query) begin
      if (stat.query_oor) begin
        distance <= UNREACHED;
        reached  <= 1'b0;
        status   <= ST_RANGE;
      end else begin
        distance <= dist_rdata;
        reached  <= dist_rdata < UNREACHED;
        status   <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb_worklist_shortest_path.sv -----
// Testbench for the worklist shortest-path block: directed table plus random traffic.
`timescale 1ns / 100ps
module tb_worklist_shortest_path;
  import wsp_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             mode;
  logic [VTX_W-1:0]       edge_from;
  logic [VTX_W-1:0]       edge_to;
  logic [WEIGHT_BITS-1:0] edge_weight;
  logic [VTX_W-1:0]       start_vertex;
  logic [VTX_W-1:0]       query_vertex;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data;
  logic                   done;
  logic [DIST_W-1:0]      distance;
  logic                   reached;
  logic [1:0]             status;

  worklist_shortest_path u_top (
    .clk, .rst, .start, .busy, .mode, .edge_from, .edge_to, .edge_weight,
    .start_vertex, .query_vertex, .cfg_valid, .cfg_ready, .cfg_data,
    .done, .distance, .reached, .status
  );

  // one result transaction
  typedef struct {
    logic [DIST_W-1:0] dval;
    logic              reach;
    status_t           st;
  } path_result_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    mode_t             op;
    logic [VTX_W-1:0]  src;
    logic [VTX_W-1:0]  dst;
    logic [15:0]       wt;
    logic [VTX_W-1:0]  sv;
    logic [VTX_W-1:0]  qv;
    bit                typed;
    logic [DIST_W-1:0] xd;
    logic              xr;
    status_t           xs;
  } sp_row_t;

  localparam int NROWS = 17;
  localparam int SETTLE_CYCLES = 400; // covers a load searching a modest table

  sp_row_t directed_rows [NROWS] = '{
    // empty table, full vertex range: run from the top vertex
    '{MODE_RUN,   0,    0,    0,     1023, 0,    1, 0,         0, ST_OK},
    '{MODE_READ,  0,    0,    0,     0,    1023, 1, 0,         1, ST_OK},
    '{MODE_READ,  0,    0,    0,     0,    0,    1, UNREACHED, 0, ST_OK},
    // extremes of weight, repeated pair, self loop, top vertex as source
    '{MODE_LOAD,  0,    1,    65535, 0,    0,    0, 0,         0, ST_OK},
    '{MODE_LOAD,  1,    2,    0,     0,    0,    0, 0,         0, ST_OK},
    '{MODE_LOAD,  0,    1,    5,     0,    0,    0, 0,         0, ST_OK},
    '{MODE_LOAD,  1023, 0,    1,     0,    0,    0, 0,         0, ST_OK},
    '{MODE_LOAD,  2,    2,    3,     0,    0,    0, 0,         0, ST_OK},
    '{MODE_LOAD,  2,    1023, 65535, 0,    0,    0, 0,         0, ST_OK},
    '{MODE_RUN,   0,    0,    0,     0,    0,    0, 0,         0, ST_OK},
    '{MODE_READ,  0,    0,    0,     0,    1,    0, 0,         0, ST_OK},
    '{MODE_READ,  0,    0,    0,     0,    2,    0, 0,         0, ST_OK},
    '{MODE_READ,  0,    0,    0,     0,    1023, 0, 0,         0, ST_OK},
    // clear drops every edge: only the start stays reached
    '{MODE_CLEAR, 0,    0,    0,     0,    0,    0, 0,         0, ST_OK},
    '{MODE_RUN,   0,    0,    0,     0,    0,    1, 0,         0, ST_OK},
    '{MODE_READ,  0,    0,    0,     0,    1,    1, UNREACHED, 0, ST_OK},
    '{MODE_READ,  0,    0,    0,     0,    0,    1, 0,         1, ST_OK}
  };

  // predictor state
  logic [VTX_W-1:0]       tbl_src [$];
  logic [VTX_W-1:0]       tbl_dst [$];
  logic [WEIGHT_BITS-1:0] tbl_wt  [$];
  bit                     tbl_ovf;
  int unsigned            dist_mem [MAX_VERTICES];
  bit                     dist_valid [MAX_VERTICES];
  int unsigned            vtx_count;

  path_result_t pending_results [$];
  int           mismatches;
  bit           quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int unsigned live_vertices();
    return vtx_count < MAX_VERTICES ? vtx_count : MAX_VERTICES;
  endfunction

  // Relax passes until nothing improves; with non-negative weights this lands
  // on the same distances as any worklist order.
  function automatic void solve_paths(input int unsigned src, input int unsigned n);
    bit          improved;
    int unsigned cand;
    for (int v = 0; v < n; v++) begin
      dist_mem[v]   = UNREACHED;
      dist_valid[v] = 1'b1;
    end
    dist_mem[src] = 0;
    do begin
      improved = 1'b0;
      for (int i = 0; i < tbl_src.size(); i++) begin
        if (tbl_src[i] < n && tbl_dst[i] < n && dist_mem[tbl_src[i]] != UNREACHED) begin
          cand = dist_mem[tbl_src[i]] + tbl_wt[i];
          if (cand < dist_mem[tbl_dst[i]]) begin
            dist_mem[tbl_dst[i]] = cand;
            improved = 1'b1;
          end
        end
      end
    end while (improved);
  endfunction

  // Updates the predictor for one accepted transaction; returns 1 with a result.
  function automatic bit path_predict(input sp_row_t r, output path_result_t res);
    int unsigned n;
    bit          hit;
    n   = live_vertices();
    res = '{0, 1'b0, ST_OK};
    case (r.op)
      MODE_LOAD: begin
        hit = 1'b0;
        foreach (tbl_src[i])
          if (!hit && tbl_src[i] == r.src && tbl_dst[i] == r.dst) begin
            tbl_wt[i] = r.wt;
            hit = 1'b1;
          end
        if (!hit) begin
          if (tbl_src.size() < MAX_EDGES) begin
            tbl_src = {tbl_src, r.src};
            tbl_dst = {tbl_dst, r.dst};
            tbl_wt  = {tbl_wt, r.wt};
          end else begin
            tbl_ovf = 1'b1;
          end
        end
        return 1'b0;
      end
      MODE_CLEAR: begin
        tbl_src.delete();
        tbl_dst.delete();
        tbl_wt.delete();
        tbl_ovf = 1'b0;
        return 1'b0;
      end
      MODE_RUN: begin
        if (r.sv >= n) begin
          res.st = ST_RANGE;
        end else begin
          solve_paths(r.sv, n);
          res.st = tbl_ovf ? ST_OVF : ST_OK;
        end
        return 1'b1;
      end
      default: begin
        if (r.qv >= n) begin
          res = '{UNREACHED, 1'b0, ST_RANGE};
        end else begin
          res.dval  = dist_mem[r.qv][DIST_W-1:0];
          res.reach = dist_mem[r.qv] < UNREACHED;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // Command transaction: optional idle gap, then hold start until busy is low.
  task automatic issue_cmd(input sp_row_t r);
    path_result_t res;
    int           gap;
    gap = 0;
    while (!quiet && $urandom_range(99) < 38) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= r.op;
    edge_from    <= r.src;
    edge_to      <= r.dst;
    edge_weight  <= r.wt;
    start_vertex <= r.sv;
    query_vertex <= r.qv;
    do @(posedge clk); while (busy);
    if (path_predict(r, res)) begin
      if (r.typed) res = '{r.xd, r.xr, r.xs};
      pending_results = {pending_results, res};
    end
  endtask

  // Drains outstanding results and lets a trailing load finish.
  task automatic drain_block();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [CNT_W-1:0] val);
    repeat ($urandom_range(3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vtx_count = val;
  endtask

  function automatic logic [VTX_W-1:0] pick_vertex(input int unsigned n);
    if ($urandom_range(99) < 15) return VTX_W'($urandom_range(1023));
    return VTX_W'($urandom_range(n + 1 > 1023 ? 1023 : n + 1));
  endfunction

  // Random transaction, mostly well-formed graph building with runs and reads.
  function automatic sp_row_t random_row();
    sp_row_t     r;
    int unsigned n, pick;
    n    = live_vertices();
    pick = $urandom_range(99);
    r    = '{MODE_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK};
    r.src = pick_vertex(n);
    r.dst = pick_vertex(n);
    r.wt  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    r.sv  = ($urandom_range(9) == 0) ? VTX_W'($urandom_range(1023))
                                     : VTX_W'($urandom_range(n == 0 ? 0 : n - 1));
    r.qv  = pick_vertex(n);
    if (tbl_src.size() > 40 || pick < 4)  r.op = MODE_CLEAR;
    else if (pick < 52)                   r.op = MODE_LOAD;
    else if (pick < 68)                   r.op = MODE_RUN;
    else                                  r.op = MODE_READ;
    // never read a distance that no run has written yet
    if (r.op == MODE_READ && r.qv < n && !dist_valid[r.qv]) r.op = MODE_RUN;
    return r;
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is a transaction.
  always @(posedge clk) begin
    path_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (distance !== want.dval)
          flag_mismatch($sformatf("distance %0d, want %0d", distance, want.dval));
        if (reached !== want.reach)
          flag_mismatch($sformatf("reached %0b, want %0b", reached, want.reach));
        if (status !== want.st)
          flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
      end
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_counts [8];
    phase_counts = '{11'd0, 11'd1, 11'd2, 11'd7, 11'd33, 11'd1024, 11'd5, 11'd2047};
    rst          = 1'b1;
    start        = 1'b0;
    mode         = MODE_LOAD;
    edge_from    = '0;
    edge_to      = '0;
    edge_weight  = '0;
    start_vertex = '0;
    query_vertex = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    mismatches   = 0;
    quiet        = 1'b0;
    tbl_ovf      = 1'b0;
    vtx_count    = MAX_VERTICES;
    foreach (dist_valid[v]) dist_valid[v] = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset vertex count
    for (int i = 0; i < NROWS; i++) issue_cmd(directed_rows[i]);

    // random part, one phase per vertex count; one phase runs with no gaps
    foreach (phase_counts[p]) begin
      drain_block();
      write_vertex_count(phase_counts[p]);
      quiet = (p == 3);
      repeat (150) issue_cmd(random_row());
    end
    quiet = 1'b0;

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
